@@ rtl/hbsw_pkg.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: shared package
// Widths, pipeline layout constants and data types used by every module of
// the block.
// ----------------------------------------------------------------------------
package hbsw_pkg;

  // Number of blended layers, one lane each.
  localparam int LAYER_COUNT = 4;

  // Field and internal widths.
  localparam int VAL_W  = 16;
  localparam int COMB_W = VAL_W + 1;
  localparam int UP_W   = COMB_W + 1;
  localparam int RAW_W  = VAL_W;
  localparam int SUM_W  = RAW_W + $clog2(LAYER_COUNT);
  localparam int QUO_W  = 16;

  // Pipeline layout: four front stages, then one divider step per stage.
  localparam int FRONT_STAGES = 4;
  localparam int DIV_STEPS    = QUO_W;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [COMB_W-1:0] comb_t;
  typedef logic [UP_W-1:0]   up_t;
  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [QUO_W-1:0]  quo_t;

  // Constants of the blend.
  localparam val_t FALLOFF_RESET = 16'd6554;
  localparam val_t MIN_FALLOFF   = 16'd33;
  localparam val_t MIN_ALPHA     = 16'd33;
  localparam sum_t MIN_SUM       = SUM_W'(3);
  localparam quo_t ONE_Q15       = 16'd32768;

endpackage

@@ rtl/hbsw_lane.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: layer lane front end
// Forms the combined height plus alpha of one layer, then its raw weight
// against the shared peak, and hands the raw weight on to the divider.
// ----------------------------------------------------------------------------
module hbsw_lane import hbsw_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  val_t  height,
  input  val_t  alpha,
  input  val_t  depth,
  input  comb_t peak,
  output comb_t comb,
  output raw_t  raw,
  output raw_t  raw_out
);

  logic  alpha_ok;
  comb_t comb_d;
  logic  alpha_ok_d;
  up_t   up;
  raw_t  raw_next;

  // Excess of combined value plus depth over the peak, floored at zero.
  // A layer with a negligible alpha contributes nothing.
  always_comb begin
    up = UP_W'(comb_d) + UP_W'(depth);
    if (alpha_ok_d && (up > UP_W'(peak))) begin
      raw_next = RAW_W'(up - UP_W'(peak));
    end else begin
      raw_next = '0;
    end
  end

  // Stage registers: combined value, its copy beside the peak, raw weight,
  // and the raw weight beside the sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      comb       <= COMB_W'(height) + COMB_W'(alpha);
      alpha_ok   <= (alpha > MIN_ALPHA);
      comb_d     <= comb;
      alpha_ok_d <= alpha_ok;
      raw        <= raw_next;
      raw_out    <= raw;
    end
  end

endmodule

@@ rtl/hbsw_merge.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: lane merge
// Finds the peak combined value over all lanes and, once the lanes have registered
// raw weights against it, the sum of those weights together with the small-sum flag.
// ----------------------------------------------------------------------------
module hbsw_merge import hbsw_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  comb_t comb [LAYER_COUNT],
  input  raw_t  raw  [LAYER_COUNT],
  output comb_t peak,
  output sum_t  sum,
  output logic  fallback
);

  comb_t peak_next;
  sum_t  sum_next;

  // Maximum and sum over the lanes.
  always_comb begin
    peak_next = '0;
    sum_next  = '0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      if (comb[i] > peak_next) begin
        peak_next = comb[i];
      end
      sum_next = sum_next + SUM_W'(raw[i]);
    end
  end

  // Peak and sum registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      peak     <= peak_next;
      sum      <= sum_next;
      fallback <= (sum_next <= MIN_SUM);
    end
  end

endmodule

@@ rtl/hbsw_div.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: pipelined normalizing divider
// Computes raw * 32768 / sum, truncated, as a restoring division with one
// quotient bit per stage. The raw weight never exceeds the sum, so the
// first step starts from the raw weight itself.
// ----------------------------------------------------------------------------
module hbsw_div import hbsw_pkg::*; (
  input  logic clk,
  input  logic adv,
  input  raw_t raw,
  input  sum_t sum,
  output quo_t quo
);

  logic [SUM_W:0] trial    [DIV_STEPS];
  logic [SUM_W:0] diff     [DIV_STEPS];
  sum_t           dvs_in   [DIV_STEPS];
  quo_t           quo_in   [DIV_STEPS];
  logic           take     [DIV_STEPS];
  sum_t           rem      [DIV_STEPS-1];
  sum_t           dvs      [DIV_STEPS-1];
  quo_t           quo_q    [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    // Partial remainder entering this step.
    if (j == 0) begin : g_first
      assign trial[j]  = (SUM_W+1)'(raw);
      assign dvs_in[j] = sum;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign trial[j]  = {rem[j-1], 1'b0};
      assign dvs_in[j] = dvs[j-1];
      assign quo_in[j] = quo_q[j-1];
    end

    // Trial subtraction decides one quotient bit.
    assign diff[j] = trial[j] - {1'b0, dvs_in[j]};
    assign take[j] = (trial[j] >= {1'b0, dvs_in[j]});

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_q[j] <= {quo_in[j][QUO_W-2:0], take[j]};
      end
    end

    // Remainder and divisor travel on to the next step.
    if (j < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dvs[j] <= dvs_in[j];
          if (take[j]) begin
            rem[j] <= diff[j][SUM_W-1:0];
          end else begin
            rem[j] <= trial[j][SUM_W-1:0];
          end
        end
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

@@ rtl/height_based_splat_weights.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: top level
// Turns four layer heights and splat alphas per texel into normalized
// Q1.15 blend weights, one lane per layer.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  -------------------------------------
//   input     in_valid / in_ready    height_0..height_3, alpha_0..alpha_3
//   output    out_valid / out_ready  weight_0..weight_3, fallback_used
//   config    cfg_we                 cfg_wdata (blend falloff)
//
// One texel is taken per cycle while in_ready is high; a result passes through
// four front stages, one stage per quotient bit of the 16-step divider in each
// lane, and the output register.
// Reset clears all valid flags and loads the falloff with 0.2 (6554).
// While an output waits, one more result parks in a skid register; only
// when that is full does the pipeline hold and in_ready drop.
// ----------------------------------------------------------------------------
module height_based_splat_weights import hbsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] height_0,
  input  logic [15:0] height_1,
  input  logic [15:0] height_2,
  input  logic [15:0] height_3,
  input  logic [15:0] alpha_0,
  input  logic [15:0] alpha_1,
  input  logic [15:0] alpha_2,
  input  logic [15:0] alpha_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] weight_0,
  output logic [15:0] weight_1,
  output logic [15:0] weight_2,
  output logic [15:0] weight_3,
  output logic        fallback_used
);

  val_t                  falloff;
  val_t                  depth;
  logic                  adv;
  logic [NUM_STAGES-1:0] vld;
  logic [DIV_STEPS-1:0]  fb_pipe;
  logic                  leave;

  val_t  heights   [LAYER_COUNT];
  val_t  alphas    [LAYER_COUNT];
  comb_t comb      [LAYER_COUNT];
  raw_t  raw       [LAYER_COUNT];
  raw_t  raw_out   [LAYER_COUNT];
  quo_t  quo       [LAYER_COUNT];
  quo_t  pipe_w    [LAYER_COUNT];
  quo_t  out_w     [LAYER_COUNT];
  quo_t  skid_w    [LAYER_COUNT];
  comb_t peak;
  sum_t  sum;
  logic  fallback;
  logic  out_fb;
  logic  skid_fb;
  logic  skid_valid;

  assign heights[0] = height_0;
  assign heights[1] = height_1;
  assign heights[2] = height_2;
  assign heights[3] = height_3;
  assign alphas[0]  = alpha_0;
  assign alphas[1]  = alpha_1;
  assign alphas[2]  = alpha_2;
  assign alphas[3]  = alpha_3;

  // Falloff register and its lower clamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      falloff <= FALLOFF_RESET;
    end else if (cfg_we) begin
      falloff <= cfg_wdata;
    end
  end

  assign depth = (falloff < MIN_FALLOFF) ? MIN_FALLOFF : falloff;

  // The whole pipeline moves together unless the skid register is full.
  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign leave    = adv && vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // Layer lanes.
  for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_lane
    hbsw_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .height  (heights[i]),
      .alpha   (alphas[i]),
      .depth   (depth),
      .peak    (peak),
      .comb    (comb[i]),
      .raw     (raw[i]),
      .raw_out (raw_out[i])
    );

    hbsw_div u_div (
      .clk (clk),
      .adv (adv),
      .raw (raw_out[i]),
      .sum (sum),
      .quo (quo[i])
    );
  end

  hbsw_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .comb     (comb),
    .raw      (raw),
    .peak     (peak),
    .sum      (sum),
    .fallback (fallback)
  );

  // Small-sum flag rides alongside the divider steps.
  always_ff @(posedge clk) begin
    if (adv) begin
      fb_pipe <= {fb_pipe[DIV_STEPS-2:0], fallback};
    end
  end

  // Default weights replace the quotients when the sum is too small.
  always_comb begin
    for (int i = 0; i < LAYER_COUNT; i++) begin
      if (!fb_pipe[DIV_STEPS-1]) begin
        pipe_w[i] = quo[i];
      end else if (i == 0) begin
        pipe_w[i] = ONE_Q15;
      end else begin
        pipe_w[i] = '0;
      end
    end
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= leave;
      end
    end else if (leave) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_w  <= skid_w;
        out_fb <= skid_fb;
      end else begin
        out_w  <= pipe_w;
        out_fb <= fb_pipe[DIV_STEPS-1];
      end
    end else if (leave) begin
      skid_w  <= pipe_w;
      skid_fb <= fb_pipe[DIV_STEPS-1];
    end
  end

  assign weight_0      = out_w[0];
  assign weight_1      = out_w[1];
  assign weight_2      = out_w[2];
  assign weight_3      = out_w[3];
  assign fallback_used = out_fb;

endmodule

@@ rtl/hbsw_checker.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module hbsw_checker import hbsw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] weight_0,
  input logic [15:0] weight_1,
  input logic [15:0] weight_2,
  input logic [15:0] weight_3,
  input logic        fallback_used
);

  logic [17:0] weight_total;

  assign weight_total = 18'(weight_0) + 18'(weight_1) + 18'(weight_2) + 18'(weight_3);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_0) && $stable(weight_1)
      && $stable(weight_2) && $stable(weight_3) && $stable(fallback_used))
    else $error("stalled result changed");

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Default weights come as one full layer 0 weight and nothing else.
  a_fallback: assert property (@(posedge clk) disable iff (rst)
    out_valid && fallback_used |-> weight_0 == ONE_Q15 && weight_1 == '0
      && weight_2 == '0 && weight_3 == '0)
    else $error("fallback weights malformed");

  // Truncated normalized weights never add up past one.
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fallback_used |-> weight_total <= 18'(ONE_Q15))
    else $error("weight total exceeds one");

  // Input back-pressure only follows a stalled output.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid) && !$past(out_ready))
    else $error("input stalled without an output stall");

endmodule

bind height_based_splat_weights hbsw_checker u_hbsw_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Height-based splat weights: testbench
// Sends texels through the input channel while both channels idle at random.
// Each result is checked against a local blend predictor or, for a few
// directed texels, against weights typed into the stimulus table. The blend
// falloff is swept over its extremes and some random values between
// phases, while the block is idle.
// ----------------------------------------------------------------------------
module testbench import hbsw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Blend rules as the predictor sees them.
  localparam int unsigned MIN_DEPTH   = 33;
  localparam int unsigned ALPHA_FLOOR = 33;
  localparam int unsigned SUM_FLOOR   = 3;
  localparam int unsigned UNITY       = 32768;

  localparam int SETTING_COUNT     = 14;
  localparam int TEXELS_PER_PHASE  = 104;
  localparam int MAX_REPORTS       = 10;
  localparam int DIRECTED_COUNT    = 20;
  localparam int SETTLE_CYCLES     = 30;

  typedef struct packed {
    val_t [LAYER_COUNT-1:0] h;
    val_t [LAYER_COUNT-1:0] a;
  } texel_t;

  typedef struct packed {
    val_t [LAYER_COUNT-1:0] w;
    logic                   fb;
  } blend_t;

  // One directed texel, with typed weights where they are obvious.
  typedef struct packed {
    val_t h0, h1, h2, h3;
    val_t a0, a1, a2, a3;
    logic known;
    val_t w0, w1, w2, w3;
    logic fb;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] height_0 = '0;
  logic [15:0] height_1 = '0;
  logic [15:0] height_2 = '0;
  logic [15:0] height_3 = '0;
  logic [15:0] alpha_0 = '0;
  logic [15:0] alpha_1 = '0;
  logic [15:0] alpha_2 = '0;
  logic [15:0] alpha_3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] weight_0;
  logic [15:0] weight_1;
  logic [15:0] weight_2;
  logic [15:0] weight_3;
  logic fallback_used;

  blend_t pending_weights [$];
  val_t   falloff_now = 16'd6554;
  int     bad_results = 0;
  int     results_checked = 0;
  int     fallbacks_seen = 0;
  int     texels_sent = 0;
  int     settings_run = 0;
  int     burst_left = 0;
  int     ready_hold = 0;
  int     ready_run = 0;
  blend_t seen;

  // Directed texels, all under the reset falloff of 6554.
  probe_t probes [DIRECTED_COUNT] = '{
    // All zero: no alpha survives, so the fallback weights appear.
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 32768, 0, 0, 0, 1},
    // Only layer 0 has alpha.
    '{0, 0, 0, 0, 32768, 0, 0, 0, 1, 32768, 0, 0, 0, 0},
    // Only layer 3 has alpha.
    '{0, 0, 0, 0, 0, 0, 0, 32768, 1, 0, 0, 0, 32768, 0},
    // Four equal layers at 1.0.
    '{32768, 32768, 32768, 32768, 32768, 32768, 32768, 32768,
      1, 8192, 8192, 8192, 8192, 0},
    // Four equal layers at the top of the field range.
    '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
      1, 8192, 8192, 8192, 8192, 0},
    // Alpha exactly at the floor is dropped.
    '{0, 32768, 0, 0, 0, 33, 0, 0, 1, 32768, 0, 0, 0, 1},
    // Alpha one above the floor is kept.
    '{0, 0, 0, 0, 0, 34, 0, 0, 1, 0, 32768, 0, 0, 0},
    // Three equal layers: truncated thirds.
    '{16384, 16384, 16384, 0, 16384, 16384, 16384, 0,
      1, 10922, 10922, 10922, 0, 0},
    // Raw sum of 2 and of 3 falls back, a sum of 4 does not.
    '{40000, 33447, 0, 0, 33, 34, 0, 0, 1, 32768, 0, 0, 0, 1},
    '{40000, 33448, 0, 0, 33, 34, 0, 0, 1, 32768, 0, 0, 0, 1},
    '{40000, 33449, 0, 0, 33, 34, 0, 0, 1, 0, 32768, 0, 0, 0},
    // Second layer sits exactly on the threshold, then one step inside it.
    '{32768, 26214, 0, 0, 32768, 32768, 0, 0, 1, 32768, 0, 0, 0, 0},
    '{32768, 26215, 0, 0, 32768, 32768, 0, 0, 0, 0, 0, 0, 0, 0},
    // Heights decide between layers of equal alpha, then a mix of heights and alphas.
    '{0, 32768, 1000, 30000, 32768, 32768, 32768, 32768, 0, 0, 0, 0, 0, 0},
    '{1234, 5678, 9012, 3456, 20000, 100, 32768, 0, 0, 0, 0, 0, 0, 0},
    // A tall layer pushes all others out of the window.
    '{65535, 0, 0, 0, 32768, 32768, 32768, 32768, 1, 32768, 0, 0, 0, 0},
    // Full-scale alpha on layer 2 alone.
    '{0, 0, 0, 0, 0, 0, 65535, 0, 1, 0, 0, 32768, 0, 0},
    // Two tied layers; the others are out of the window or dropped.
    '{1000, 20000, 0, 20000, 500, 12768, 40, 12768, 1, 0, 16384, 0, 16384, 0},
    // Two layers inside the window with unequal raw weights.
    '{0, 0, 0, 0, 32768, 30000, 0, 0, 0, 0, 0, 0, 0, 0},
    // Smallest kept alpha on every layer.
    '{0, 0, 0, 0, 34, 34, 34, 34, 1, 8192, 8192, 8192, 8192, 0}
  };

  height_based_splat_weights dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_0      (height_0),
    .height_1      (height_1),
    .height_2      (height_2),
    .height_3      (height_3),
    .alpha_0       (alpha_0),
    .alpha_1       (alpha_1),
    .alpha_2       (alpha_2),
    .alpha_3       (alpha_3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .weight_0      (weight_0),
    .weight_1      (weight_1),
    .weight_2      (weight_2),
    .weight_3      (weight_3),
    .fallback_used (fallback_used)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Normalized blend weights of one texel under the given falloff.
  function automatic blend_t blend_weights(input texel_t t, input val_t falloff);
    int unsigned depth;
    int unsigned peak;
    int unsigned up;
    int unsigned sum;
    int unsigned comb [LAYER_COUNT];
    int unsigned raw [LAYER_COUNT];
    blend_t r;
    depth = (falloff < MIN_DEPTH) ? MIN_DEPTH : falloff;
    peak = 0;
    sum = 0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      comb[i] = t.h[i] + t.a[i];
      if (comb[i] > peak) peak = comb[i];
    end
    for (int i = 0; i < LAYER_COUNT; i++) begin
      up = comb[i] + depth;
      raw[i] = (up > peak) ? up - peak : 0;
      if (t.a[i] <= ALPHA_FLOOR) raw[i] = 0;
      sum += raw[i];
    end
    r = '0;
    if (sum <= SUM_FLOOR) begin
      r.w[0] = val_t'(UNITY);
      r.fb = 1'b1;
    end else begin
      for (int i = 0; i < LAYER_COUNT; i++)
        r.w[i] = val_t'((64'(raw[i]) * UNITY) / sum);
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one texel and wait for its transfer; the expectation is queued then.
  task automatic push_texel(input texel_t t, input logic known, input blend_t typed);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    height_0 <= t.h[0];
    height_1 <= t.h[1];
    height_2 <= t.h[2];
    height_3 <= t.h[3];
    alpha_0 <= t.a[0];
    alpha_1 <= t.a[1];
    alpha_2 <= t.a[2];
    alpha_3 <= t.a[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_weights.push_back(known ? typed : blend_weights(t, falloff_now));
    texels_sent++;
  endtask

  // Wait until every expected result has come back, then let the pipe settle.
  task automatic drain_results();
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result receiver: ready-high runs broken by stalls of random length.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      if (ready_run > 0) begin
        ready_run--;
      end else begin
        ready_hold = idle_len();
        ready_run = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(0, 5);
      end
    end
  end

  // Result checker: each output transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.w[0] = weight_0;
      seen.w[1] = weight_1;
      seen.w[2] = weight_2;
      seen.w[3] = weight_3;
      seen.fb = fallback_used;
      if (seen.fb === 1'b1) fallbacks_seen++;
      if (pending_weights.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: w=%0d,%0d,%0d,%0d fb=%0d",
                   seen.w[0], seen.w[1], seen.w[2], seen.w[3], seen.fb);
      end else begin
        blend_t want;
        want = pending_weights.pop_front();
        results_checked++;
        if (seen !== want) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("result %0d: expected w=%0d,%0d,%0d,%0d fb=%0d, got w=%0d,%0d,%0d,%0d fb=%0d",
                     results_checked, want.w[0], want.w[1], want.w[2], want.w[3],
                     want.fb, seen.w[0], seen.w[1], seen.w[2], seen.w[3], seen.fb);
        end
      end
    end
  end

  // Stimulus: reset, directed texels, then random texels per falloff setting.
  initial begin
    val_t   falloffs [SETTING_COUNT];
    texel_t t;
    probe_t pr;
    blend_t typed;
    int unsigned depth;
    int kind;
    int p;
    int l;
    int tgt;
    int lo;
    int hi;
    int span;
    int hb;
    int ab;
    int s;

    falloffs = '{16'd6554, 16'd0, 16'd65535, 16'd33, 16'd32, 16'd1, 16'd34,
                 16'd3277, 16'd32768, 16'd300, 16'd0, 16'd0, 16'd0, 16'd0};
    for (int k = SETTING_COUNT - 4; k < SETTING_COUNT; k++)
      falloffs[k] = val_t'($urandom_range(0, 65535));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < SETTING_COUNT; k++) begin
      // The first phase runs on the reset falloff; later ones write it first.
      if (k > 0) begin
        in_valid <= 1'b0;
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= falloffs[k];
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      falloff_now = falloffs[k];
      settings_run++;
      depth = (falloff_now < MIN_DEPTH) ? MIN_DEPTH : falloff_now;

      if (k == 0) begin
        for (int j = 0; j < DIRECTED_COUNT; j++) begin
          pr = probes[j];
          t.h = {pr.h3, pr.h2, pr.h1, pr.h0};
          t.a = {pr.a3, pr.a2, pr.a1, pr.a0};
          typed.w = {pr.w3, pr.w2, pr.w1, pr.w0};
          typed.fb = pr.fb;
          push_texel(t, pr.known, typed);
        end
      end

      for (int j = 0; j < TEXELS_PER_PHASE; j++) begin
        t = '0;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          // Ordinary texel within the documented range.
          for (int i = 0; i < LAYER_COUNT; i++) begin
            t.h[i] = val_t'($urandom_range(0, UNITY));
            t.a[i] = val_t'($urandom_range(0, UNITY));
          end
        end else if (kind < 55) begin
          // Any 16-bit value.
          for (int i = 0; i < LAYER_COUNT; i++) begin
            t.h[i] = val_t'($urandom);
            t.a[i] = val_t'($urandom);
          end
        end else if (kind < 75) begin
          // Layers clustered so that several fall inside the window.
          span = depth / 2;
          hb = $urandom_range(0, UNITY);
          ab = $urandom_range(0, UNITY);
          for (int i = 0; i < LAYER_COUNT; i++) begin
            s = hb + $urandom_range(0, span);
            t.h[i] = (s > 65535) ? 16'hFFFF : val_t'(s);
            s = ab + $urandom_range(0, span);
            t.a[i] = (s > 65535) ? 16'hFFFF : val_t'(s);
          end
        end else if (kind < 85) begin
          // Alphas around the floor.
          for (int i = 0; i < LAYER_COUNT; i++) begin
            t.h[i] = val_t'($urandom_range(0, UNITY));
            t.a[i] = val_t'($urandom_range(0, 40));
          end
        end else begin
          // Dropped peak layer and one layer just past the threshold, so
          // the raw sum lands near the fallback limit.
          p = $urandom_range(0, LAYER_COUNT - 1);
          l = (p + $urandom_range(1, LAYER_COUNT - 1)) % LAYER_COUNT;
          t.a[p] = val_t'($urandom_range(0, ALPHA_FLOOR));
          t.h[p] = val_t'($urandom_range(0, 65535));
          tgt = int'(t.h[p]) + int'(t.a[p]) + $urandom_range(0, 5) - int'(depth);
          if (tgt > int'(ALPHA_FLOOR)) begin
            lo = (tgt > 65535) ? tgt - 65535 : 0;
            if (lo <= int'(ALPHA_FLOOR)) lo = ALPHA_FLOOR + 1;
            hi = (tgt > 65535) ? 65535 : tgt;
            t.a[l] = val_t'($urandom_range(lo, hi));
            t.h[l] = val_t'(tgt - int'(t.a[l]));
          end
        end
        push_texel(t, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d texels over %0d falloff settings, including 0 and 65535.",
             results_checked, texels_sent, settings_run);
    $display("%0d results took the fallback weights; %0d results were wrong.",
             fallbacks_seen, bad_results);
    if (bad_results == 0 && pending_weights.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Run stopped by the watchdog with %0d results outstanding.",
             pending_weights.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hbsw_pkg.sv
rtl/hbsw_lane.sv
rtl/hbsw_merge.sv
rtl/hbsw_div.sv
rtl/height_based_splat_weights.sv
rtl/hbsw_checker.sv
tb/sv/testbench.sv
